### hw/rtl/page_map_reference_checker_assert.svh
// Assertion macros used by the page map reference checker sequencer.
`ifndef PAGE_MAP_REFERENCE_CHECKER_ASSERT_SVH
`define PAGE_MAP_REFERENCE_CHECKER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PMRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PMRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pmrc_pkg.sv
// Package with the shared types, sizes and codes of the page map reference checker.
`timescale 1ns / 1ps

package pmrc_pkg;

  localparam int MapWords = 4096;
  localparam int WordW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int Cap      = MapWords * 32;
  localparam int PageW    = WordW + 5;
  localparam int CapW     = $clog2(Cap + 1);
  localparam int CntW     = $clog2(MapWords + 1);
  localparam int SumW     = ((CapW > 17) ? CapW : 17) + 1;
  localparam int CovW     = SumW + 8;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 18;

  localparam logic [CfgIdxW-1:0] CfgPageSizeLog2 = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPageCount    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgActiveMap    = 2'd2;

  typedef enum logic [1:0] {
    ModeLoad     = 2'd0,
    ModeReserved = 2'd1,
    ModeData     = 2'd2,
    ModeSweep    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk          = 2'd0,
    StatusBadPage     = 2'd1,
    StatusMarkedFree  = 2'd2,
    StatusUnreferenced = 2'd3
  } status_e;

  typedef struct packed {
    logic [4:0]      log2;
    logic [CapW-1:0] count;
    logic [CntW-1:0] sweep_words;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [WordW-1:0] waddr;
    logic [31:0]      wdata;
    logic             re;
    logic [WordW-1:0] raddr;
  } ram_req_t;

endpackage

### hw/rtl/pmrc_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module pmrc_ram #(
  parameter int Depth = 4096,
  parameter int Width = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hw/rtl/pmrc_ctrl.sv
// Sequencer for bitmap loads, claims and sweeps, with error latch and result register.
`timescale 1ns / 1ps

module pmrc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pmrc_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             mode_i,
  input  logic [11:0]            word_index_i,
  input  logic [31:0]            value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [31:0]            error_page_o,
  output pmrc_pkg::ram_req_t     ram_req_o,
  input  logic [31:0]            ram_rdata_i
);

  typedef enum logic [1:0] {
    StIdle,
    StClaim,
    StSweep,
    StFinish
  } state_e;

  state_e                          state_q, state_d;
  logic                            failed_q, failed_d;
  pmrc_pkg::status_e               lstat_q, lstat_d;
  logic [31:0]                     lpage_q, lpage_d;
  logic [pmrc_pkg::PageW-1:0]      page_q, page_d;
  logic [pmrc_pkg::WordW-1:0]      chk_q, chk_d;
  logic                            out_valid_q, out_valid_d;
  pmrc_pkg::status_e               out_status_q, out_status_d;
  logic [31:0]                     out_page_q, out_page_d;

  pmrc_pkg::ram_req_t              req;
  pmrc_pkg::mode_e                 mode;
  logic                            finish;
  logic                            out_free;
  logic [31:0]                     low_mask;
  logic [31:0]                     low_bits;
  logic                            data_bad;
  logic [4:0]                      zero_bit;

  function automatic logic [4:0] first_zero(input logic [31:0] w);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!w[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

  assign mode     = pmrc_pkg::mode_e'(mode_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign low_mask = ~(32'hFFFF_FFFF << cfg_i.log2);
  assign low_bits = value_i & low_mask;
  assign data_bad = (value_i == 32'd0) || (value_i >= 32'(cfg_i.count)) ||
                    (low_bits == 32'd1) || (low_bits == 32'd2);
  assign zero_bit = first_zero(ram_rdata_i);

  always_comb begin
    state_d      = state_q;
    failed_d     = failed_q;
    lstat_d      = lstat_q;
    lpage_d      = lpage_q;
    page_d       = page_q;
    chk_d        = chk_q;
    finish       = 1'b0;
    req.we       = 1'b0;
    req.waddr    = pmrc_pkg::WordW'(word_index_i);
    req.wdata    = value_i;
    req.re       = 1'b0;
    req.raddr    = value_i[pmrc_pkg::PageW-1:5];

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (failed_q) begin
            finish = 1'b1;
          end else begin
            unique case (mode)
              pmrc_pkg::ModeLoad: begin
                req.we = (32'(word_index_i) < 32'(pmrc_pkg::MapWords));
                finish = 1'b1;
              end
              pmrc_pkg::ModeReserved: begin
                if (value_i < 32'(pmrc_pkg::Cap)) begin
                  req.re  = 1'b1;
                  page_d  = value_i[pmrc_pkg::PageW-1:0];
                  state_d = StClaim;
                end else begin
                  finish = 1'b1;
                end
              end
              pmrc_pkg::ModeData: begin
                if (data_bad) begin
                  failed_d = 1'b1;
                  lstat_d  = pmrc_pkg::StatusBadPage;
                  lpage_d  = value_i;
                  finish   = 1'b1;
                end else begin
                  req.re  = 1'b1;
                  page_d  = value_i[pmrc_pkg::PageW-1:0];
                  state_d = StClaim;
                end
              end
              pmrc_pkg::ModeSweep: begin
                if (cfg_i.sweep_words == '0) begin
                  finish = 1'b1;
                end else begin
                  req.re    = 1'b1;
                  req.raddr = '0;
                  chk_d     = '0;
                  state_d   = StSweep;
                end
              end
              default: begin
                finish = 1'b1;
              end
            endcase
          end
        end
      end
      StClaim: begin
        req.we    = 1'b1;
        req.waddr = page_q[pmrc_pkg::PageW-1:5];
        req.wdata = ram_rdata_i | (32'd1 << page_q[4:0]);
        if (ram_rdata_i[page_q[4:0]]) begin
          failed_d = 1'b1;
          lstat_d  = pmrc_pkg::StatusMarkedFree;
          lpage_d  = 32'(page_q);
        end
        finish = 1'b1;
      end
      StSweep: begin
        if (ram_rdata_i != 32'hFFFF_FFFF) begin
          failed_d = 1'b1;
          lstat_d  = pmrc_pkg::StatusUnreferenced;
          lpage_d  = 32'({chk_q, zero_bit});
          finish   = 1'b1;
        end else if (pmrc_pkg::CntW'(chk_q) + pmrc_pkg::CntW'(1) == cfg_i.sweep_words) begin
          finish = 1'b1;
        end else begin
          chk_d     = chk_q + pmrc_pkg::WordW'(1);
          req.re    = 1'b1;
          req.raddr = chk_q + pmrc_pkg::WordW'(1);
        end
      end
      StFinish: begin
        finish = 1'b1;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_page_d   = out_page_q;
    if (finish) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_status_d = failed_d ? lstat_d : pmrc_pkg::StatusOk;
        out_page_d   = failed_d ? lpage_d : 32'd0;
        state_d      = StIdle;
      end else begin
        state_d = StFinish;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      failed_q    <= 1'b0;
      lstat_q     <= pmrc_pkg::StatusOk;
      lpage_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      failed_q    <= failed_d;
      lstat_q     <= lstat_d;
      lpage_q     <= lpage_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q       <= page_d;
    chk_q        <= chk_d;
    out_status_q <= out_status_d;
    out_page_q   <= out_page_d;
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign error_page_o = out_page_q;
  assign ram_req_o    = req;

`include "page_map_reference_checker_assert.svh"

  `PMRC_ASSERT_NEXT(a_latch_sticks, failed_q, failed_q, "error latch cleared without reset")
  `PMRC_ASSERT_NOW(a_no_write_after_fail, failed_q, !req.we, "bitmap written after an error")
  `PMRC_ASSERT_NOW(a_no_write_in_sweep, state_q == StSweep, !req.we, "bitmap written during sweep")
  `PMRC_ASSERT_NEXT(a_result_held, out_valid_q && out_stall_i,
                    out_valid_q && $stable(out_status_q) && $stable(out_page_q),
                    "stalled result changed")

endmodule

### hw/rtl/page_map_reference_checker.sv
// Top level of the page map reference checker: configuration registers, bitmap memory
// and sequencer.
`timescale 1ns / 1ps

// The free-page bitmap sits in one memory with a registered read port. A bitmap load,
// a rejected page number, an ignored reserved claim, an empty sweep or any transaction
// after an error finishes straight from idle, without a bitmap read. A page claim reads
// its bitmap word and then writes it back. A sweep reads one word per cycle; it stops
// at the first word with a clear bit, so a passing sweep reads every covered word, up
// to the whole map. Results go to an output register, so a new transaction is accepted
// while a result still waits. The bitmap is not cleared after reset; every word a claim
// or sweep touches must be loaded first. Configuration writes take effect at once.
module page_map_reference_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [17:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [11:0] word_index_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] error_page_o
);

  logic [4:0]                    log2_q;
  logic [17:0]                   count_q;
  logic [1:0]                    amap_q;

  logic [4:0]                    log2_eff;
  logic [pmrc_pkg::CapW-1:0]     count_eff;
  logic [pmrc_pkg::SumW-1:0]     span_sum;
  logic [pmrc_pkg::SumW-1:0]     span_n;
  logic [pmrc_pkg::CovW-1:0]     cover_words;
  pmrc_pkg::cfg_t                cfg;
  pmrc_pkg::ram_req_t            ram_req;
  logic [31:0]                   ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q  <= 5'd12;
      count_q <= '0;
      amap_q  <= 2'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pmrc_pkg::CfgPageSizeLog2: log2_q  <= cfg_wdata_i[4:0];
        pmrc_pkg::CfgPageCount:    count_q <= cfg_wdata_i;
        pmrc_pkg::CfgActiveMap:    amap_q  <= cfg_wdata_i[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (log2_q < 5'd6) begin
      log2_eff = 5'd6;
    end else if (log2_q > 5'd16) begin
      log2_eff = 5'd16;
    end else begin
      log2_eff = log2_q;
    end
  end

  assign count_eff = (32'(count_q) > 32'(pmrc_pkg::Cap)) ?
                     pmrc_pkg::CapW'(pmrc_pkg::Cap) : pmrc_pkg::CapW'(count_q);

  assign span_sum = pmrc_pkg::SumW'(count_eff) +
                    (pmrc_pkg::SumW'(1) << log2_eff) -
                    ((amap_q == 2'd2) ? pmrc_pkg::SumW'(2) : pmrc_pkg::SumW'(1));
  assign span_n      = span_sum >> log2_eff;
  assign cover_words = pmrc_pkg::CovW'(span_n) << (log2_eff - 5'd2);

  assign cfg.log2        = log2_eff;
  assign cfg.count       = count_eff;
  assign cfg.sweep_words = (cover_words > pmrc_pkg::CovW'(pmrc_pkg::MapWords)) ?
                           pmrc_pkg::CntW'(pmrc_pkg::MapWords) :
                           pmrc_pkg::CntW'(cover_words);

  pmrc_ram #(
    .Depth(pmrc_pkg::MapWords),
    .Width(32)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_req.we),
    .waddr_i(ram_req.waddr),
    .wdata_i(ram_req.wdata),
    .re_i   (ram_req.re),
    .raddr_i(ram_req.raddr),
    .rdata_o(ram_rdata)
  );

  pmrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .word_index_i(word_index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .error_page_o(error_page_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

endmodule
